FILE: hdl/serial_keyword_command_parser_top_assert.svh
`ifndef SERIAL_KEYWORD_COMMAND_PARSER_TOP_ASSERT_SVH
`define SERIAL_KEYWORD_COMMAND_PARSER_TOP_ASSERT_SVH

// same-cycle implication
`define SKCP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("skcp assertion failed");

// next-cycle implication
`define SKCP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("skcp assertion failed");

`endif

FILE: hdl/skcp_pkg.sv
package skcp_pkg;

	localparam int TDATA_W = 48;
	localparam int TUSER_W = 2;
	localparam int PAD_W   = 4;

	typedef enum logic [1:0] {
		KIND_KEYWORD = 2'd0,
		KIND_NUMBER  = 2'd1,
		KIND_TEXT    = 2'd2,
		KIND_EMPTY   = 2'd3
	} kind_t;

	typedef enum logic [0:0] {
		OP_STORE = 1'b0,
		OP_END   = 1'b1
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [7:0] ch;
	} cmd_t;

	typedef struct packed {
		logic       hit;
		logic [2:0] code;
	} kw_hit_t;

	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_A     = 8'h41;
	localparam logic [7:0] CH_NUL   = 8'h00;

	localparam logic [2:0] KW_HORA = 3'd4;

	// first three letters of each keyword, code order
	localparam logic [23:0] KW_HEAD [8] = '{
		"VEL", "ANO", "DIA", "MES", "HOR", "SEM", "MIN", "SEG"
	};

	// h0..h2 hold stored text, b is the byte being appended
	function automatic kw_hit_t kw_lookup(input logic [7:0] h0, input logic [7:0] h1,
		input logic [7:0] h2, input logic [7:0] b, input logic at2, input logic at3);
		kw_hit_t r;
		r = '0;
		for (int k = 0; k < 8; k++) begin
			if (3'(k) == KW_HORA) begin
				if (at3 && {h0, h1, h2} == KW_HEAD[k] && b == CH_A) begin
					r.hit  = 1'b1;
					r.code = 3'(k);
				end
			end else if (at2 && {h0, h1, b} == KW_HEAD[k]) begin
				r.hit  = 1'b1;
				r.code = 3'(k);
			end
		end
		return r;
	endfunction

endpackage

FILE: hdl/skcp_fifo.sv
module skcp_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  skcp_pkg::cmd_t    push_cmd,
	input  logic              pop,
	output logic              valid,
	output skcp_pkg::cmd_t    head,
	output logic              full
);

	localparam int DEPTH = 4;
	localparam int PTR_W = $clog2(DEPTH);

	skcp_pkg::cmd_t   mem_q [DEPTH];
	logic [PTR_W-1:0] wp_q;
	logic [PTR_W-1:0] rp_q;
	logic [PTR_W:0]   cnt_q;

	assign valid = (cnt_q != '0);
	assign full  = (cnt_q == (PTR_W+1)'(DEPTH));
	assign head  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= rp_q + 1'b1;
			end
			cnt_q <= cnt_q + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
		end
	end

endmodule

FILE: hdl/skcp_front.sv
module skcp_front (
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        s_tdata,
	input  logic              q_full,
	output logic              push,
	output skcp_pkg::cmd_t    push_cmd
);

	logic skip;

	// line control characters never reach the store
	assign skip = (s_tdata == skcp_pkg::CH_LF) || (s_tdata == skcp_pkg::CH_FF)
		|| (s_tdata == skcp_pkg::CH_CR);

	assign s_tready = !q_full;
	assign push     = s_tvalid && !q_full && !skip;

	always_comb begin
		push_cmd.ch = s_tdata;
		push_cmd.op = (s_tdata == skcp_pkg::CH_STAR) ? skcp_pkg::OP_END : skcp_pkg::OP_STORE;
	end

endmodule

FILE: hdl/skcp_back.sv
module skcp_back #(
	parameter int STORE_LEN = 20
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_valid,
	input  skcp_pkg::cmd_t                q_cmd,
	output logic                          pop,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [skcp_pkg::TDATA_W-1:0]  m_tdata,
	output logic [skcp_pkg::TUSER_W-1:0]  m_tuser,
	output logic                          m_tlast
);

	localparam int IDX_W = $clog2(STORE_LEN);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_NUM  = 4'b0010,
		ST_TXT  = 4'b0100,
		ST_FIN  = 4'b1000
	} state_t;

	state_t           state_q, state_d;
	logic [7:0]       mem [STORE_LEN];
	logic [7:0]       rd_q;
	logic [7:0]       hd_q [3];
	logic [IDX_W-1:0] fill_q, fill_d;
	logic [IDX_W-1:0] idx_q, idx_d;
	logic             pend_q, pend_d;
	logic [2:0]       pkw_q, pkw_d;
	logic             drop_q, drop_d;
	logic [31:0]      acc_q, acc_d;
	logic             neg_q, neg_d;
	logic             ws_q, ws_d;
	logic [7:0]       hold_q, hold_d;
	logic             held_q, held_d;

	logic             ov_q;
	skcp_pkg::kind_t  okind_q;
	logic [2:0]       okw_q;
	logic [31:0]      oval_q;
	logic [7:0]       otb_q;
	logic             olast_q;
	logic             oovf_q;

	logic             out_free;
	logic             we;
	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;
	logic             emit;
	skcp_pkg::kind_t  e_kind;
	logic [2:0]       e_kw;
	logic [31:0]      e_val;
	logic [7:0]       e_tb;
	logic             e_last;
	logic             at_end;
	logic             is_ws;
	logic             is_sign;
	logic             is_dig;
	logic [3:0]       dig;
	logic             store_full;
	skcp_pkg::kw_hit_t kw;

	assign out_free   = !ov_q || m_tready;
	assign at_end     = (idx_q == fill_q) || (rd_q == skcp_pkg::CH_NUL);
	assign is_ws      = (rd_q == skcp_pkg::CH_SP)
		|| (rd_q >= skcp_pkg::CH_TAB && rd_q <= skcp_pkg::CH_CR);
	assign is_sign    = (rd_q == skcp_pkg::CH_PLUS) || (rd_q == skcp_pkg::CH_MINUS);
	assign is_dig     = (rd_q >= skcp_pkg::CH_0) && (rd_q <= skcp_pkg::CH_9);
	assign dig        = 4'(rd_q - skcp_pkg::CH_0);
	assign store_full = (fill_q >= IDX_W'(STORE_LEN - 1));
	assign kw = skcp_pkg::kw_lookup(hd_q[0], hd_q[1], hd_q[2], q_cmd.ch,
		fill_q == IDX_W'(2), fill_q == IDX_W'(3));

	always_comb begin
		state_d = state_q;
		fill_d  = fill_q;
		idx_d   = idx_q;
		pend_d  = pend_q;
		pkw_d   = pkw_q;
		drop_d  = drop_q;
		acc_d   = acc_q;
		neg_d   = neg_q;
		ws_d    = ws_q;
		hold_d  = hold_q;
		held_d  = held_q;
		pop     = 1'b0;
		we      = 1'b0;
		rd_en   = 1'b0;
		rd_addr = idx_q + 1'b1;
		emit    = 1'b0;
		e_kind  = skcp_pkg::KIND_TEXT;
		e_kw    = '0;
		e_val   = '0;
		e_tb    = '0;
		e_last  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					if (q_cmd.op == skcp_pkg::OP_END) begin
						pop     = 1'b1;
						rd_en   = 1'b1;
						rd_addr = '0;
						idx_d   = '0;
						acc_d   = '0;
						neg_d   = 1'b0;
						ws_d    = 1'b1;
						held_d  = 1'b0;
						state_d = pend_q ? ST_NUM : ST_TXT;
					end else if (store_full) begin
						pop    = 1'b1;
						drop_d = 1'b1;
					end else if (out_free) begin
						pop    = 1'b1;
						we     = 1'b1;
						fill_d = fill_q + 1'b1;
						if (kw.hit) begin
							emit   = 1'b1;
							e_kind = skcp_pkg::KIND_KEYWORD;
							e_kw   = kw.code;
							e_last = 1'b1;
							fill_d = '0;
							pend_d = 1'b1;
							pkw_d  = kw.code;
						end
					end
				end
			end
			ST_NUM: begin
				if (at_end) begin
					state_d = ST_FIN;
				end else if (ws_q && is_ws) begin
					idx_d = idx_q + 1'b1;
					rd_en = 1'b1;
				end else if (ws_q && is_sign) begin
					neg_d = (rd_q == skcp_pkg::CH_MINUS);
					ws_d  = 1'b0;
					idx_d = idx_q + 1'b1;
					rd_en = 1'b1;
				end else if (is_dig) begin
					acc_d = (acc_q << 3) + (acc_q << 1) + {28'd0, dig};
					ws_d  = 1'b0;
					idx_d = idx_q + 1'b1;
					rd_en = 1'b1;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_TXT: begin
				if (!held_q) begin
					if (at_end) begin
						if (out_free) begin
							emit    = 1'b1;
							e_kind  = skcp_pkg::KIND_EMPTY;
							e_last  = 1'b1;
							fill_d  = '0;
							pend_d  = 1'b0;
							pkw_d   = '0;
							drop_d  = 1'b0;
							state_d = ST_IDLE;
						end
					end else begin
						hold_d = rd_q;
						held_d = 1'b1;
						idx_d  = idx_q + 1'b1;
						rd_en  = 1'b1;
					end
				end else if (out_free) begin
					emit = 1'b1;
					e_tb = hold_q;
					if (at_end) begin
						e_last  = 1'b1;
						fill_d  = '0;
						pend_d  = 1'b0;
						pkw_d   = '0;
						drop_d  = 1'b0;
						state_d = ST_IDLE;
					end else begin
						hold_d = rd_q;
						idx_d  = idx_q + 1'b1;
						rd_en  = 1'b1;
					end
				end
			end
			ST_FIN: begin
				if (out_free) begin
					emit    = 1'b1;
					e_kind  = skcp_pkg::KIND_NUMBER;
					e_kw    = pkw_q;
					e_val   = neg_q ? (32'd0 - acc_q) : acc_q;
					e_last  = 1'b1;
					fill_d  = '0;
					pend_d  = 1'b0;
					pkw_d   = '0;
					drop_d  = 1'b0;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// text store, one write and one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[fill_q] <= q_cmd.ch;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
		if (we && fill_q < IDX_W'(3)) begin
			hd_q[fill_q[1:0]] <= q_cmd.ch;
		end
	end

	always_ff @(posedge clk) begin
		acc_q  <= acc_d;
		neg_q  <= neg_d;
		ws_q   <= ws_d;
		hold_q <= hold_d;
		idx_q  <= idx_d;
		if (emit) begin
			okind_q <= e_kind;
			okw_q   <= e_kw;
			oval_q  <= e_val;
			otb_q   <= e_tb;
			olast_q <= e_last;
			oovf_q  <= drop_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q  <= '0;
			pend_q  <= 1'b0;
			pkw_q   <= '0;
			drop_q  <= 1'b0;
			held_q  <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			fill_q  <= fill_d;
			pend_q  <= pend_d;
			pkw_q   <= pkw_d;
			drop_q  <= drop_d;
			held_q  <= held_d;
			if (emit) begin
				ov_q <= 1'b1;
			end else if (m_tready) begin
				ov_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = ov_q;
	assign m_tuser  = okind_q;
	assign m_tlast  = olast_q;
	assign m_tdata  = {{skcp_pkg::PAD_W{1'b0}}, oovf_q, otb_q, oval_q, okw_q};

endmodule

FILE: hdl/serial_keyword_command_parser_top.sv
// channel  dir  tdata (low bit up)                                 tuser  tlast
// s_axis   in   rx_byte[7:0]                                       -      -
// m_axis   out  keyword[2:0] value[34:3] text_byte[42:35]          kind   last
//               overflowed[43] zero[47:44]
//
// a stored byte is written into the back end's store, an ignored byte never reaches it
// a '*' ends a command and starts the read-back of its text characters or of its number field
// the front takes a byte each cycle while the four-word queue has room
// reset clears all control state at once, no clearing pass over the store
// a stalled result holds the back end; the front keeps filling the queue
module serial_keyword_command_parser_top #(
	parameter int STORE_LEN = 20
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,  // rx_byte
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// keyword, value, text_byte, overflowed, zero pad
	output logic [skcp_pkg::TDATA_W-1:0]  m_tdata,
	output logic [skcp_pkg::TUSER_W-1:0]  m_tuser,  // kind
	output logic                          m_tlast
);

	logic           push;
	skcp_pkg::cmd_t push_cmd;
	logic           q_full;
	logic           q_valid;
	skcp_pkg::cmd_t q_cmd;
	logic           pop;

	skcp_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.q_full   (q_full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	skcp_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.valid    (q_valid),
		.head     (q_cmd),
		.full     (q_full)
	);

	skcp_back #(
		.STORE_LEN (STORE_LEN)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_cmd    (q_cmd),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

FILE: hdl/skcp_chk.sv
`include "serial_keyword_command_parser_top_assert.svh"

module skcp_chk (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [skcp_pkg::TDATA_W-1:0]  m_tdata,
	input logic [skcp_pkg::TUSER_W-1:0]  m_tuser,
	input logic                          m_tlast
);

	// a stalled word keeps its contents
	`SKCP_ASSERT_NXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

	// keyword, number and empty results are single-word responses
	`SKCP_ASSERT_IMP(a_single_last, clk, arst_n, m_tvalid && m_tuser != skcp_pkg::KIND_TEXT, m_tlast)

	// text words carry a non-zero character and no keyword or value
	`SKCP_ASSERT_IMP(a_text_only, clk, arst_n, m_tvalid && m_tuser == skcp_pkg::KIND_TEXT, m_tdata[42:35] != 8'h00 && m_tdata[34:0] == 35'd0)

	// only a number result carries a value
	`SKCP_ASSERT_IMP(a_value_number, clk, arst_n, m_tvalid && m_tuser != skcp_pkg::KIND_NUMBER, m_tdata[34:3] == 32'd0)

endmodule

bind serial_keyword_command_parser_top skcp_chk u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
